>>> design/single_linkage_clustering_unit_defines.svh
// Assertion macros for the single linkage clustering unit.
// No dependencies; included by modules that carry assertions.
`ifndef SINGLE_LINKAGE_CLUSTERING_UNIT_DEFINES_SVH
`define SINGLE_LINKAGE_CLUSTERING_UNIT_DEFINES_SVH
// implication checked every clock, off during reset
`define SLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SLC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/slc_pkg.sv
// Shared constants for the single linkage clustering unit.
// No dependencies.
package slc_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBadTarget = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;
endpackage

>>> design/single_linkage_clustering_unit.sv
// Channel  Handshake            Payload
// cfg      cfg_valid/cfg_ready  cfg_data (target_clusters)
// in       in_valid/in_ready    point_ident coord_x coord_y last_point
// out      out_valid/out_ready  cluster_number out_ident out_x out_y status last_result
// Points are loaded in turn. After the last point, labels are set up; each merge
// scans all N(N-1)/2 pairs, drains the two-stage distance pipe and relabels.
// Ranking follows, then the points are emitted one by one; an error gives a
// single result.
// Synchronous reset; no clearing pass. A stalled result holds the controller,
// while points of the next run are still taken behind the final result.
// Top level: clustering controller plus point store and distance datapath.
// Depends on slc_pkg, slc_ctrl, slc_datapath.
module single_linkage_clustering_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] point_ident,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic        last_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  cluster_number,
  output logic [30:0] out_ident,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [1:0]  status,
  output logic        last_result
);
  import slc_pkg::*;
  logic we, lbl_we, dist_en, cmp_en, clr_best, found;
  logic [IdxW-1:0] waddr, lbl_waddr, lbl_wdata, pa, qa, rd_lp, blo, bhi;
  logic [30:0] rd_ident;
  logic [15:0] rd_x, rd_y;

  slc_ctrl u_ctrl (.*);

  slc_datapath u_dp (
    .clk, .rst, .we, .waddr, .wident(point_ident), .wx(coord_x), .wy(coord_y),
    .lbl_we, .lbl_waddr, .lbl_wdata, .pa, .qa, .dist_en, .cmp_en, .clr_best,
    .rd_ident, .rd_x, .rd_y, .rd_lp, .found, .blo, .bhi
  );
endmodule

>>> design/slc_datapath.sv
// Datapath: point and label stores, pair distance and best-pair tracking.
// Depends on slc_pkg.
`include "single_linkage_clustering_unit_defines.svh"
module slc_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    we,
  input  logic [slc_pkg::IdxW-1:0] waddr,
  input  logic [30:0]             wident,
  input  logic [15:0]             wx,
  input  logic [15:0]             wy,
  input  logic                    lbl_we,
  input  logic [slc_pkg::IdxW-1:0] lbl_waddr,
  input  logic [slc_pkg::IdxW-1:0] lbl_wdata,
  input  logic [slc_pkg::IdxW-1:0] pa,
  input  logic [slc_pkg::IdxW-1:0] qa,
  input  logic                    dist_en,
  input  logic                    cmp_en,
  input  logic                    clr_best,
  output logic [30:0]             rd_ident,
  output logic [15:0]             rd_x,
  output logic [15:0]             rd_y,
  output logic [slc_pkg::IdxW-1:0] rd_lp,
  output logic                    found,
  output logic [slc_pkg::IdxW-1:0] blo,
  output logic [slc_pkg::IdxW-1:0] bhi
);
  import slc_pkg::*;
  logic [30:0] ident_mem [MaxPoints];
  logic [15:0] x_mem [MaxPoints];
  logic [15:0] y_mem [MaxPoints];
  logic [IdxW-1:0] lbl_mem [MaxPoints];
  logic [15:0] rq_x, rq_y;
  logic [IdxW-1:0] rd_lq;
  logic [16:0] dx, dy;
  logic [33:0] dxx, dyy;
  logic [34:0] sq_dist, best;
  logic        pair_ok;
  logic [IdxW-1:0] lo_r, hi_r, lo_c, hi_c;

  always_ff @(posedge clk) begin
    if (we) begin
      ident_mem[waddr] <= wident;
      x_mem[waddr] <= wx;
      y_mem[waddr] <= wy;
    end
    if (lbl_we) lbl_mem[lbl_waddr] <= lbl_wdata;
    rd_ident <= ident_mem[pa];
    rd_x <= x_mem[pa];
    rd_y <= y_mem[pa];
    rd_lp <= lbl_mem[pa];
    rq_x <= x_mem[qa];
    rq_y <= y_mem[qa];
    rd_lq <= lbl_mem[qa];
  end

  assign dx = {rd_x[15], rd_x} - {rq_x[15], rq_x};
  assign dy = {rd_y[15], rd_y} - {rq_y[15], rq_y};
  assign lo_c = (rd_lp < rd_lq) ? rd_lp : rd_lq;
  assign hi_c = (rd_lp < rd_lq) ? rd_lq : rd_lp;

  // stage 1: squares; stage 2: sum and compare
  always_ff @(posedge clk) begin
    if (dist_en) begin
      dxx <= 34'($signed(dx) * $signed(dx));
      dyy <= 34'($signed(dy) * $signed(dy));
      lo_r <= lo_c;
      hi_r <= hi_c;
      pair_ok <= (rd_lp != rd_lq);
    end
  end
  assign sq_dist = {1'b0, dxx} + {1'b0, dyy};

  always_ff @(posedge clk) begin
    if (rst || clr_best) begin
      found <= 1'b0;
    end else if (cmp_en && pair_ok) begin
      if (!found || sq_dist < best ||
          (sq_dist == best && (lo_r < blo || (lo_r == blo && hi_r < bhi)))) begin
        found <= 1'b1;
        best <= sq_dist;
        blo <= lo_r;
        bhi <= hi_r;
      end
    end
  end

  `SLC_ASSERT_NXT(a_found_hold, found && !clr_best && !rst, found, "best pair lost")
  `SLC_ASSERT_IMP(a_best_order, found, blo < bhi, "best pair out of order")
  `SLC_ASSERT_NXT(a_clr, clr_best, !found, "best pair not cleared")
endmodule

>>> design/slc_ctrl.sv
// Controller: load, merge scan, relabel, rank and ordered emit sequencing.
// Depends on slc_pkg.
`include "single_linkage_clustering_unit_defines.svh"
module slc_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [6:0]              cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    last_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [5:0]              cluster_number,
  output logic [30:0]             out_ident,
  output logic [15:0]             out_x,
  output logic [15:0]             out_y,
  output logic [1:0]              status,
  output logic                    last_result,
  output logic                    we,
  output logic [slc_pkg::IdxW-1:0] waddr,
  output logic                    lbl_we,
  output logic [slc_pkg::IdxW-1:0] lbl_waddr,
  output logic [slc_pkg::IdxW-1:0] lbl_wdata,
  output logic [slc_pkg::IdxW-1:0] pa,
  output logic [slc_pkg::IdxW-1:0] qa,
  output logic                    dist_en,
  output logic                    cmp_en,
  output logic                    clr_best,
  input  logic [30:0]             rd_ident,
  input  logic [15:0]             rd_x,
  input  logic [15:0]             rd_y,
  input  logic [slc_pkg::IdxW-1:0] rd_lp,
  input  logic                    found,
  input  logic [slc_pkg::IdxW-1:0] blo,
  input  logic [slc_pkg::IdxW-1:0] bhi
);
  import slc_pkg::*;
  typedef enum logic [11:0] {
    S_LOAD = 12'b000000000001, S_INIT = 12'b000000000010,
    S_SCAN = 12'b000000000100, S_DRAIN = 12'b000000001000,
    S_RELBL = 12'b000000010000, S_RANK = 12'b000000100000,
    S_PICK = 12'b000001000000, S_PWAIT = 12'b000010000000,
    S_PCMP = 12'b000100000000, S_EMIT = 12'b001000000000,
    S_OUT = 12'b010000000000, S_ERR = 12'b100000000000
  } state_t;
  state_t state;
  logic [6:0] target;
  logic [CntW-1:0] count, clusters, p, q, k, r;
  logic overflow;
  logic [1:0] err_st;
  logic [1:0] drain;
  logic [MaxPoints-1:0] done;
  logic [IdxW-1:0] rank [MaxPoints];
  logic [IdxW-1:0] best_p, best_rank;
  logic [30:0] best_id;
  logic have_best;
  logic [IdxW-1:0] rank_p;
  logic pk_valid;  // registered pick candidate ready
  logic [30:0] pk_ident;
  logic [IdxW-1:0] pk_idx;
  logic rd_valid;  // pair read issued last cycle

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_LOAD);

  always_comb begin
    we = in_valid && in_ready && (count < CntW'(MaxPoints));
    waddr = count[IdxW-1:0];
    lbl_we = 1'b0;
    lbl_waddr = p[IdxW-1:0];
    lbl_wdata = p[IdxW-1:0];
    pa = p[IdxW-1:0];
    qa = q[IdxW-1:0];
    dist_en = rd_valid;
    cmp_en = (drain != 2'd0);
    clr_best = (state == S_INIT && p == count - 1'b1) ||
               (state == S_RELBL && p == count);
    case (state)
      S_INIT: lbl_we = 1'b1;
      S_RELBL: begin
        lbl_we = rd_valid && (rd_lp == bhi);
        lbl_waddr = IdxW'(p - 1'b1);
        lbl_wdata = blo;
      end
      S_PCMP: pa = best_p;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      target <= 7'd1;
      count <= '0;
      overflow <= 1'b0;
      out_valid <= 1'b0;
      drain <= '0;
      rd_valid <= 1'b0;
      pk_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) target <= cfg_data;
      rd_valid <= 1'b0;
      drain <= {drain[0], rd_valid && (state == S_SCAN || state == S_DRAIN)};
      if (out_valid && out_ready) out_valid <= 1'b0;
      // pick pipeline: rank lookup is registered, compare in the next cycle
      pk_valid <= rd_valid && (state == S_PICK);
      rank_p <= rank[rd_lp];
      pk_ident <= rd_ident;
      pk_idx <= IdxW'(p - 1'b1);
      if (pk_valid && !done[pk_idx] &&
          (!have_best || rank_p < best_rank ||
           (rank_p == best_rank && pk_ident < best_id))) begin
        have_best <= 1'b1;
        best_rank <= rank_p;
        best_id <= pk_ident;
        best_p <= pk_idx;
      end
      case (state)
        S_LOAD: begin
          if (in_valid && in_ready) begin
            if (count < CntW'(MaxPoints)) count <= count + 1'b1;
            else overflow <= 1'b1;
            if (last_point) begin
              p <= '0;
              if (overflow || count >= CntW'(MaxPoints)) begin
                err_st <= StOverflow;
                state <= S_ERR;
              end else if (target == 7'd0 || target > 7'(count + 1'b1)) begin
                err_st <= StBadTarget;
                state <= S_ERR;
              end else begin
                state <= S_INIT;
                clusters <= count + 1'b1;
                count <= count + 1'b1;
              end
            end
          end
        end
        S_ERR: begin
          if (!out_valid) begin
            cluster_number <= '0;
            out_ident <= '0;
            out_x <= '0;
            out_y <= '0;
            status <= err_st;
            last_result <= 1'b1;
            out_valid <= 1'b1;
            count <= '0;
            overflow <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_INIT: begin
          if (p == count - 1'b1) begin
            p <= '0;
            if (clusters > CntW'(target) && clusters > CntW'(1)) begin
              q <= CntW'(1);
              state <= S_SCAN;
            end else begin
              r <= '0;
              state <= S_RANK;
            end
          end else p <= p + 1'b1;
        end
        S_SCAN: begin
          rd_valid <= 1'b1;
          if (q == count - 1'b1) begin
            if (p + 2'd2 >= count) state <= S_DRAIN;
            else begin
              p <= p + 1'b1;
              q <= p + 2'd2;
            end
          end else q <= q + 1'b1;
        end
        S_DRAIN: begin
          if (!rd_valid && drain == 2'd0) begin
            p <= '0;
            state <= found ? S_RELBL : S_RANK;
            if (!found) r <= '0;
          end
        end
        S_RELBL: begin
          if (p == count) begin
            clusters <= clusters - 1'b1;
            p <= '0;
            if (clusters - 1'b1 > CntW'(target) && clusters - 1'b1 > CntW'(1)) begin
              q <= CntW'(1);
              state <= S_SCAN;
            end else begin
              r <= '0;
              state <= S_RANK;
            end
          end else begin
            rd_valid <= 1'b1;
            p <= p + 1'b1;
          end
        end
        S_RANK: begin
          // label[p]==p marks cluster heads in load order
          if (rd_valid && rd_lp == IdxW'(p - 1'b1)) begin
            rank[IdxW'(p - 1'b1)] <= r[IdxW-1:0];
            r <= r + 1'b1;
          end
          if (p == count) begin
            done <= '0;
            k <= '0;
            p <= '0;
            have_best <= 1'b0;
            state <= S_PICK;
          end else begin
            rd_valid <= 1'b1;
            p <= p + 1'b1;
          end
        end
        S_PICK: begin
          // scan for smallest (rank, id, index) not yet emitted
          if (p == count) state <= S_PWAIT;
          else begin
            rd_valid <= 1'b1;
            p <= p + 1'b1;
          end
        end
        S_PWAIT: state <= S_PCMP;
        S_PCMP: begin
          p <= CntW'(best_p);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            cluster_number <= best_rank;
            out_ident <= rd_ident;
            out_x <= rd_x;
            out_y <= rd_y;
            status <= StOk;
            last_result <= (k == count - 1'b1);
            out_valid <= 1'b1;
            done[best_p] <= 1'b1;
            k <= k + 1'b1;
            p <= '0;
            have_best <= 1'b0;
            if (k == count - 1'b1) begin
              count <= '0;
              state <= S_LOAD;
            end else state <= S_PICK;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `SLC_ASSERT_IMP(a_in_idle, in_ready, state == S_LOAD, "input taken while busy")
  `SLC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `SLC_ASSERT_IMP(a_cnt, state != S_LOAD, count <= CntW'(MaxPoints), "count overflow")
endmodule
